/* src/smm_pkg.sv */
// Package for the square matrix multiply core.
// Holds the command codes and the transaction and control structs; no dependencies.
package smm_pkg;

    // Width of the dimension register and of the row and column fields.
    localparam int DIM_W       = 5;
    localparam int IDX_FIELD_W = 4;
    localparam int DATA_W      = 32;

    localparam logic [DIM_W-1:0] DIM_RESET = 5'd16;

    // Command codes; the remaining code is ignored.
    typedef enum logic [1:0] {
        CMD_WR_A = 2'd0,
        CMD_WR_B = 2'd1,
        CMD_READ = 2'd2
    } t_cmd;

    // One input transaction.
    typedef struct packed {
        t_cmd                          cmd;
        logic [IDX_FIELD_W-1:0]        row;
        logic [IDX_FIELD_W-1:0]        col;
        logic signed [DATA_W-1:0]      value;
    } t_in_item;

    // One result transaction.
    typedef struct packed {
        logic signed [DATA_W-1:0]      product;
        logic [IDX_FIELD_W-1:0]        out_row;
        logic [IDX_FIELD_W-1:0]        out_col;
    } t_out_item;

    // Write control for one cell.
    typedef struct packed {
        logic                          we_a;
        logic                          we_b;
        logic [IDX_FIELD_W-1:0]        addr;
    } t_wr;

    // Read token that travels down the cell chain.
    typedef struct packed {
        logic                          valid;
        logic [IDX_FIELD_W-1:0]        row;
        logic [IDX_FIELD_W-1:0]        col;
    } t_tok;

endpackage

/* src/smm_cell.sv */
// One cell of the multiply chain: holds column k of A and row k of B.
// Depends on smm_pkg for the write and token structs.
module smm_cell
    import smm_pkg::*;
#(
    parameter int MAX_DIM    = 16,
    parameter int ELEM_WIDTH = 32,
    parameter int IDX_W      = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_wr                   i_wr,
    input  logic [ELEM_WIDTH-1:0] i_wdata,
    input  t_tok                  i_tok,
    input  logic [ELEM_WIDTH-1:0] i_sum,
    output t_tok                  o_tok,
    output logic [ELEM_WIDTH-1:0] o_sum
);

    logic [ELEM_WIDTH-1:0] mem_a [MAX_DIM];
    logic [ELEM_WIDTH-1:0] mem_b [MAX_DIM];

    logic [IDX_W-1:0]      w_waddr;
    logic [IDX_W-1:0]      w_raddr_a;
    logic [IDX_W-1:0]      w_raddr_b;

    logic                  r_v1;
    logic                  r_v2;
    logic [IDX_FIELD_W-1:0] r_row1;
    logic [IDX_FIELD_W-1:0] r_col1;
    logic [IDX_FIELD_W-1:0] r_row2;
    logic [IDX_FIELD_W-1:0] r_col2;
    logic [ELEM_WIDTH-1:0] r_a;
    logic [ELEM_WIDTH-1:0] r_b;
    logic [ELEM_WIDTH-1:0] r_sum1;
    logic [ELEM_WIDTH-1:0] r_sum2;
    logic [ELEM_WIDTH-1:0] w_prod;
    logic [ELEM_WIDTH-1:0] n_sum2;

    // A is addressed by row, B by column of the requested element.
    assign w_waddr   = IDX_W'(i_wr.addr);
    assign w_raddr_a = IDX_W'(i_tok.row);
    assign w_raddr_b = IDX_W'(i_tok.col);

    // Local element storage with registered read data.
    always_ff @(posedge i_clk) begin
        if (i_wr.we_a) begin
            mem_a[w_waddr] <= i_wdata;
        end
        if (i_wr.we_b) begin
            mem_b[w_waddr] <= i_wdata;
        end
        r_a <= mem_a[w_raddr_a];
        r_b <= mem_b[w_raddr_b];
    end

    // Token payload follows the data through both stages.
    always_ff @(posedge i_clk) begin
        r_row1 <= i_tok.row;
        r_col1 <= i_tok.col;
        r_sum1 <= i_sum;
        r_row2 <= r_row1;
        r_col2 <= r_col1;
        r_sum2 <= n_sum2;
    end

    // Token valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_tok.valid;
            r_v2 <= r_v1;
        end
    end

    // Multiply-accumulate; the low bits are the same for signed operands.
    assign w_prod = r_a * r_b;
    assign n_sum2 = r_sum1 + w_prod;

    assign o_tok = '{valid: r_v2, row: r_row2, col: r_col2};
    assign o_sum = r_sum2;

endmodule

/* src/square_matrix_multiply_core.sv */
// Square integer matrix multiplier: a write of A or B stores one element, and a read of
// element (row, col) of A*B returns one result with o_done after passing the chain of dim
// multiply-accumulate cells at two stages each and then the result register; a dim
// of zero counts as one and a dim above MAX_DIM counts as MAX_DIM. busy stays high until
// the result shows and drops with it, so the next command can be accepted at the edge
// that ends the result cycle.
// A read outside the configured dimension returns zero in the cycle after acceptance.
// Results are shown for exactly one cycle and cannot be held off by the receiver.
// Depends on smm_pkg and smm_cell.
module square_matrix_multiply_core
    import smm_pkg::*;
#(
    parameter int MAX_DIM    = 16,
    parameter int ELEM_WIDTH = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  t_in_item         i_item,
    output logic             o_done,
    output t_out_item        o_result,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [DIM_W-1:0] i_cfg_data
);

    localparam int IDX_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int EW    = $clog2(MAX_DIM + 1);
    localparam int CW    = (EW > DIM_W) ? EW : DIM_W;

    logic [DIM_W-1:0]      r_dim;
    logic                  r_busy;
    logic                  r_done;
    t_out_item             r_result;

    logic [CW-1:0]         w_dim_ext;
    logic [EW-1:0]         w_eff;
    logic [IDX_W-1:0]      w_tap;
    logic                  w_accept;
    logic                  w_in_store;
    logic                  w_in_range;
    logic                  w_launch;
    logic [ELEM_WIDTH-1:0] w_wdata;

    t_wr                   w_wr     [MAX_DIM];
    t_tok                  w_tok_in [MAX_DIM];
    t_tok                  w_tok_out[MAX_DIM];
    logic [ELEM_WIDTH-1:0] w_sum_in [MAX_DIM];
    logic [ELEM_WIDTH-1:0] w_sum_out[MAX_DIM];
    t_tok                  w_tap_tok;
    logic [ELEM_WIDTH-1:0] w_tap_sum;

    // Effective dimension: zero counts as one, large values saturate.
    assign w_dim_ext = CW'(r_dim);
    always_comb begin
        if (w_dim_ext == '0) begin
            w_eff = EW'(1);
        end else if (w_dim_ext > CW'(MAX_DIM)) begin
            w_eff = EW'(MAX_DIM);
        end else begin
            w_eff = EW'(w_dim_ext);
        end
    end
    assign w_tap = IDX_W'(w_eff - EW'(1));

    // Command decode.
    assign w_accept   = start && !r_busy;
    assign w_in_store = (int'(i_item.row) < MAX_DIM) && (int'(i_item.col) < MAX_DIM);
    assign w_in_range = (int'(i_item.row) < int'(w_eff)) && (int'(i_item.col) < int'(w_eff));
    assign w_launch   = w_accept && (i_item.cmd == CMD_READ) && w_in_range;
    assign w_wdata    = ELEM_WIDTH'(i_item.value);

    // Cell chain; the token stops at the cell of the last used index.
    for (genvar k = 0; k < MAX_DIM; k++) begin : g_cell
        assign w_wr[k].we_a = w_accept && w_in_store && (i_item.cmd == CMD_WR_A)
                              && (int'(i_item.col) == k);
        assign w_wr[k].we_b = w_accept && w_in_store && (i_item.cmd == CMD_WR_B)
                              && (int'(i_item.row) == k);
        assign w_wr[k].addr = (i_item.cmd == CMD_WR_A) ? i_item.row : i_item.col;

        if (k == 0) begin : g_head
            assign w_tok_in[k] = '{valid: w_launch, row: i_item.row, col: i_item.col};
            assign w_sum_in[k] = '0;
        end else begin : g_link
            assign w_tok_in[k].valid = w_tok_out[k-1].valid && (w_tap != IDX_W'(k - 1));
            assign w_tok_in[k].row   = w_tok_out[k-1].row;
            assign w_tok_in[k].col   = w_tok_out[k-1].col;
            assign w_sum_in[k]       = w_sum_out[k-1];
        end

        smm_cell #(
            .MAX_DIM    (MAX_DIM),
            .ELEM_WIDTH (ELEM_WIDTH),
            .IDX_W      (IDX_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_wr    (w_wr[k]),
            .i_wdata (w_wdata),
            .i_tok   (w_tok_in[k]),
            .i_sum   (w_sum_in[k]),
            .o_tok   (w_tok_out[k]),
            .o_sum   (w_sum_out[k])
        );
    end

    assign w_tap_tok = w_tok_out[w_tap];
    assign w_tap_sum = w_sum_out[w_tap];

    // Dimension register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dim <= DIM_RESET;
        end else if (i_cfg_valid) begin
            r_dim <= i_cfg_data;
        end
    end

    // Busy from an in-range read until its sum leaves the chain.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            if (w_launch) begin
                r_busy <= 1'b1;
            end else if (w_tap_tok.valid) begin
                r_busy <= 1'b0;
            end
            r_done <= w_tap_tok.valid
                      || (w_accept && (i_item.cmd == CMD_READ) && !w_in_range);
        end
    end

    // Result payload: chain sum or zero for a read outside the dimension.
    always_ff @(posedge i_clk) begin
        if (w_tap_tok.valid) begin
            r_result.product <= DATA_W'($signed(w_tap_sum));
            r_result.out_row <= w_tap_tok.row;
            r_result.out_col <= w_tap_tok.col;
        end else begin
            r_result.product <= '0;
            r_result.out_row <= i_item.row;
            r_result.out_col <= i_item.col;
        end
    end

    assign busy        = r_busy;
    assign o_done      = r_done;
    assign o_result    = r_result;
    assign o_cfg_ready = 1'b1;

endmodule

/* src/smm_checker.sv */
// Port-level checker for the square matrix multiply core, bound to the top level.
// Depends on smm_pkg for the transaction structs.
module smm_port_assertions
    import smm_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      start,
    input logic      busy,
    input logic      o_done,
    input t_out_item o_result
);

    // A result never shows while a read is in flight.
    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(busy && o_done))
        else $error("result shown while busy");

    // Busy only rises after a command was offered.
    a_busy_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy rose without a start");

    // The end of a read always delivers its result.
    a_busy_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_done)
        else $error("busy fell without a result");

    // A result right after an idle cycle is a read outside the dimension.
    a_oor_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !$past(busy)) |-> (o_result.product == '0))
        else $error("out-of-range read returned a nonzero product");

endmodule

bind square_matrix_multiply_core smm_port_assertions u_smm_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_done   (o_done),
    .o_result (o_result)
);

/* test/smm_checker.sv */
// Checker for the square matrix multiply core: watches the command, result and
// dimension channels, keeps its own copy of both matrices and compares each result.
// Depends on smm_pkg.
module smm_checker
    import smm_pkg::*;
#(
    parameter int MAX_DIM = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic             i_busy,
    input  t_in_item         i_item,
    input  logic             i_done,
    input  t_out_item        i_result,
    input  logic             i_cfg_valid,
    input  logic             i_cfg_ready,
    input  logic [DIM_W-1:0] i_cfg_data,
    output int               o_fail_count,
    output int               o_pending,
    output int               o_result_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_REPORTS = 10;

    // Shadow copies of the two matrices, row-major, and of the dimension register.
    logic signed [DATA_W-1:0] a_cells [MAX_DIM*MAX_DIM];
    logic signed [DATA_W-1:0] b_cells [MAX_DIM*MAX_DIM];
    logic [DIM_W-1:0]         dim_reg = DIM_RESET;

    // Product elements still owed by the block, oldest first.
    t_out_item owed_products [$];
    int        fail_count   = 0;
    int        result_count = 0;

    // A dimension of zero acts as one; anything above the storage saturates.
    function automatic int dim_in_use(logic [DIM_W-1:0] d);
        if (d == 0) begin
            return 1;
        end
        if (d > MAX_DIM) begin
            return MAX_DIM;
        end
        return int'(d);
    endfunction

    // Dot product of row of A and column of B, wrapping at the data width.
    function automatic t_out_item product_element(t_in_item req);
        t_out_item         res;
        int                span;
        int                k;
        logic [DATA_W-1:0] acc;
        span = dim_in_use(dim_reg);
        acc  = '0;
        if (req.row < span && req.col < span) begin
            for (k = 0; k < span; k++) begin
                acc += a_cells[req.row*MAX_DIM + k] * b_cells[k*MAX_DIM + req.col];
            end
        end
        res.product = acc;
        res.out_row = req.row;
        res.out_col = req.col;
        return res;
    endfunction

    // Everything is sampled at the rising edge, before the block updates its outputs.
    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            dim_reg = DIM_RESET;
            owed_products.delete();
        end else begin
            // Result channel: compare against the oldest owed element.
            if (i_done) begin
                result_count++;
                if (owed_products.size() == 0) begin
                    if (fail_count < MAX_REPORTS) begin
                        $display("%0t: unexpected result product=%0d row=%0d col=%0d",
                                 $realtime, i_result.product, i_result.out_row,
                                 i_result.out_col);
                    end
                    fail_count++;
                end else begin
                    want = owed_products.pop_front();
                    if (i_result !== want) begin
                        if (fail_count < MAX_REPORTS) begin
                            $display("%0t: mismatch expected product=%0d row=%0d col=%0d",
                                     $realtime, want.product, want.out_row, want.out_col);
                            $display("%0t:          actual   product=%0d row=%0d col=%0d",
                                     $realtime, i_result.product, i_result.out_row,
                                     i_result.out_col);
                        end
                        fail_count++;
                    end
                end
            end

            // Command channel: writes update the shadow matrices, reads owe a result.
            if (i_start && !i_busy) begin
                case (i_item.cmd)
                    CMD_WR_A: begin
                        if (i_item.row < MAX_DIM && i_item.col < MAX_DIM) begin
                            a_cells[i_item.row*MAX_DIM + i_item.col] = i_item.value;
                        end
                    end
                    CMD_WR_B: begin
                        if (i_item.row < MAX_DIM && i_item.col < MAX_DIM) begin
                            b_cells[i_item.row*MAX_DIM + i_item.col] = i_item.value;
                        end
                    end
                    CMD_READ: begin
                        owed_products.push_back(product_element(i_item));
                    end
                    default: begin
                    end
                endcase
            end

            // Dimension register transaction.
            if (i_cfg_valid && i_cfg_ready) begin
                dim_reg = i_cfg_data;
            end
        end
        o_fail_count   = fail_count;
        o_pending      = owed_products.size();
        o_result_count = result_count;
    end

endmodule

/* test/square_matrix_multiply_core_tb.sv */
// Top of the square matrix multiply core testbench: clock, reset, command and
// dimension stimulus, and the verdict. Depends on smm_pkg, smm_checker and the core.
module square_matrix_multiply_core_tb;
    import smm_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          MAX_DIM       = 16;
    localparam int          ELEM_WIDTH    = 32;
    localparam int          RANDOM_ITEMS  = 1650;
    localparam int          NUM_PHASES    = 10;
    localparam int          SETTLE_CYCLES = 2*MAX_DIM + 8;
    localparam int          MAX_GAP       = 30;
    // Sized for every transaction at worst gap plus a full-size read each, with a wide margin.
    localparam int          CYCLE_LIMIT   = 1000000;
    localparam logic [1:0]  CMD_IGNORED   = 2'd3;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             start;
    logic             busy;
    t_in_item         cmd_item;
    logic             done;
    t_out_item        result_item;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [DIM_W-1:0] cfg_data;

    int fail_count;
    int pending;
    int result_count;

    // Stimulus-side bookkeeping: which cells hold data, current dimension, load.
    bit               a_written [MAX_DIM*MAX_DIM];
    bit               b_written [MAX_DIM*MAX_DIM];
    logic [DIM_W-1:0] dim_now;
    int               idle_pct;
    int               sent_items;
    int               random_items;
    int               cycle_count = 0;
    int               phases_run  = 0;

    always #6 clk = ~clk;

    square_matrix_multiply_core #(
        .MAX_DIM    (MAX_DIM),
        .ELEM_WIDTH (ELEM_WIDTH)
    ) DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .start       (start),
        .busy        (busy),
        .i_item      (cmd_item),
        .o_done      (done),
        .o_result    (result_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    smm_checker #(
        .MAX_DIM (MAX_DIM)
    ) u_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_start        (start),
        .i_busy         (busy),
        .i_item         (cmd_item),
        .i_done         (done),
        .i_result       (result_item),
        .i_cfg_valid    (cfg_valid),
        .i_cfg_ready    (cfg_ready),
        .i_cfg_data     (cfg_data),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_result_count (result_count)
    );

    // Watchdog on the total run length.
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Run stopped by the watchdog after %0d cycles.", cycle_count);
            $display("simulation failed");
            $finish;
        end
    end

    function automatic int span_of(logic [DIM_W-1:0] d);
        if (d == 0) begin
            return 1;
        end
        if (d > MAX_DIM) begin
            return MAX_DIM;
        end
        return int'(d);
    endfunction

    // Element values lean on the extremes of the signed range.
    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 32'sh7fff_ffff;
            1: return 32'sh8000_0000;
            2: return '0;
            3: return -32'sd1;
            4: return $signed($urandom_range(0, 16)) - 8;
            default: return $urandom;
        endcase
    endfunction

    // One command transaction: optional idle gap, then hold start until accepted.
    task automatic send_item(t_in_item it);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(0, 99) < idle_pct) begin
            gap++;
        end
        @(negedge clk);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start    <= 1'b1;
        cmd_item <= it;
        do @(posedge clk); while (busy);
        if (it.cmd != t_cmd'(CMD_IGNORED)) begin
            sent_items++;
        end
    endtask

    task automatic write_cell(t_cmd which, int r, int c, logic signed [DATA_W-1:0] v);
        t_in_item it;
        it.cmd   = which;
        it.row   = IDX_FIELD_W'(r);
        it.col   = IDX_FIELD_W'(c);
        it.value = v;
        if (which == CMD_WR_A) begin
            a_written[r*MAX_DIM + c] = 1'b1;
        end else begin
            b_written[r*MAX_DIM + c] = 1'b1;
        end
        send_item(it);
    endtask

    // A read in range first fills any cell of its row of A or column of B not yet written.
    task automatic read_element(int r, int c);
        t_in_item it;
        int       span;
        int       k;
        span = span_of(dim_now);
        if (r < span && c < span) begin
            for (k = 0; k < span; k++) begin
                if (!a_written[r*MAX_DIM + k]) begin
                    write_cell(CMD_WR_A, r, k, pick_value());
                end
                if (!b_written[k*MAX_DIM + c]) begin
                    write_cell(CMD_WR_B, k, c, pick_value());
                end
            end
        end
        it.cmd   = CMD_READ;
        it.row   = IDX_FIELD_W'(r);
        it.col   = IDX_FIELD_W'(c);
        it.value = $urandom;
        send_item(it);
    endtask

    // Stop sending and wait until every owed result has arrived.
    task automatic drain_results();
        @(negedge clk);
        start <= 1'b0;
        while (pending != 0) @(negedge clk);
    endtask

    // Dimension register transaction, only with the block idle.
    task automatic set_dim(logic [DIM_W-1:0] d);
        drain_results();
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= d;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        dim_now = d;
        phases_run++;
    endtask

    // One random transaction mix: reads in and out of range, writes, ignored commands, drains.
    task automatic random_step();
        t_in_item it;
        int       span;
        int       sel;
        int       r;
        int       c;
        span = span_of(dim_now);
        sel  = $urandom_range(0, 99);
        if (sel < 40) begin
            read_element($urandom_range(0, span-1), $urandom_range(0, span-1));
        end else if (sel < 50) begin
            read_element($urandom_range(0, 15), $urandom_range(0, 15));
        end else if (sel < 90) begin
            r = ($urandom_range(0, 99) < 70) ? $urandom_range(0, span-1) : $urandom_range(0, 15);
            c = ($urandom_range(0, 99) < 70) ? $urandom_range(0, span-1) : $urandom_range(0, 15);
            write_cell($urandom_range(0, 1) ? CMD_WR_B : CMD_WR_A, r, c, pick_value());
        end else if (sel < 96) begin
            it.cmd   = t_cmd'(CMD_IGNORED);
            it.row   = IDX_FIELD_W'($urandom_range(0, 15));
            it.col   = IDX_FIELD_W'($urandom_range(0, 15));
            it.value = $urandom;
            send_item(it);
        end else begin
            drain_results();
        end
    endtask

    initial begin
        logic [DIM_W-1:0] phase_dims [NUM_PHASES];
        t_in_item         it;
        int               p;
        int               phase_start;

        rst_n      = 1'b0;
        start      = 1'b0;
        cmd_item   = '0;
        cfg_valid  = 1'b0;
        cfg_data   = '0;
        dim_now    = DIM_RESET;
        idle_pct   = 38;
        sent_items = 0;
        phase_dims = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd3, 5'd17, 5'd8, 5'd0, 5'd16, 5'd5};
        phase_dims[7] = DIM_W'($urandom_range(0, 31));

        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        // Directed part on a 2x2 window: extreme values and their wrapped products.
        set_dim(5'd2);
        write_cell(CMD_WR_A, 0, 0, 32'sh7fff_ffff);
        write_cell(CMD_WR_A, 0, 1, 32'sh8000_0000);
        write_cell(CMD_WR_B, 0, 0, 32'sh7fff_ffff);
        write_cell(CMD_WR_B, 1, 0, 32'sh8000_0000);
        read_element(0, 0);
        write_cell(CMD_WR_A, 1, 0, -32'sd1);
        write_cell(CMD_WR_A, 1, 1, 32'sd1);
        read_element(1, 0);
        write_cell(CMD_WR_B, 0, 1, -32'sd1);
        write_cell(CMD_WR_B, 1, 1, '0);
        read_element(0, 1);
        read_element(1, 1);
        // Cells outside the window are stored and only count once the window grows.
        write_cell(CMD_WR_A, 15, 15, -32'sd1);
        write_cell(CMD_WR_B, 15, 15, 32'sh8000_0000);
        // The unused command code must be dropped without a result.
        it.cmd   = t_cmd'(CMD_IGNORED);
        it.row   = 4'hf;
        it.col   = 4'hf;
        it.value = -32'sd1;
        send_item(it);
        // Reads outside the window return zero with the indices echoed; a last read in range follows.
        read_element(15, 15);
        read_element(2, 0);
        read_element(0, 2);
        read_element(1, 1);

        // Random phases, each under its own dimension setting.
        random_items = 0;
        for (p = 0; p < NUM_PHASES; p++) begin
            set_dim(phase_dims[p]);
            while (random_items < (p + 1) * RANDOM_ITEMS / NUM_PHASES) begin
                if (random_items < RANDOM_ITEMS / 3) begin
                    idle_pct = 38;
                end else if (random_items < 2 * RANDOM_ITEMS / 3) begin
                    idle_pct = 60;
                end else begin
                    idle_pct = 0;
                end
                phase_start = sent_items;
                random_step();
                random_items += sent_items - phase_start;
            end
        end

        // Let the last results come in, then give the block time to settle.
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Sent %0d matrix transactions and checked %0d product elements.",
                 sent_items, result_count);
        $display("Covered %0d dimension settings, zero and values past the storage size included.",
                 phases_run);
        if (pending != 0) begin
            $display("%0d product elements never arrived.", pending);
        end
        if (fail_count == 0 && pending == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

/* files.f */
src/smm_pkg.sv
src/smm_cell.sv
src/square_matrix_multiply_core.sv
src/smm_checker.sv
test/smm_checker.sv
test/square_matrix_multiply_core_tb.sv
